// ===== rtl/conv2d_valid_or_same_padding_assert.svh =====
// assertion macros for the convolution engine
`ifndef CONV2D_VALID_OR_SAME_PADDING_ASSERT_SVH
`define CONV2D_VALID_OR_SAME_PADDING_ASSERT_SVH

// same-cycle implication
`define C2D_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("c2d assertion failed");

// next-cycle implication
`define C2D_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("c2d assertion failed");

`endif

// ===== rtl/c2d_pkg.sv =====
// shared types and constants of the convolution engine
`timescale 1ns / 1ps

package c2d_pkg;

  localparam int MAX_DIM    = 64;
  localparam int MAX_KERNEL = 16;
  localparam int DATA_WIDTH = 16;

  localparam int SUM_W      = 40;
  localparam int POS_W      = 6;
  localparam int KIND_W     = 2;
  localparam int STAT_W     = 2;
  localparam int KSZ_W      = 5;
  localparam int DIM_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int KIDX_W     = $clog2(MAX_KERNEL);
  localparam int PIDX_W     = $clog2(MAX_DIM);
  localparam int TAP_W      = POS_W + 2;
  localparam int PROD_W     = 2 * DATA_WIDTH;

  localparam logic [KSZ_W-1:0] KSZ_RESET = KSZ_W'(3);
  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(64);

  typedef enum logic [KIND_W-1:0] {
    KIND_KWR  = 2'd0,
    KIND_PWR  = 2'd1,
    KIND_CONV = 2'd2,
    KIND_RSVD = 2'd3
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_GEOM  = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KSIZE = 2'd0,
    CFG_IDIM  = 2'd1,
    CFG_PAD   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [KIND_W-1:0]            kind;
    logic [POS_W-1:0]             row;
    logic [POS_W-1:0]             col;
    logic signed [DATA_WIDTH-1:0] data_value;
  } c2d_in_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] conv_sum;
    logic [STAT_W-1:0]       status;
  } c2d_out_t;

  typedef struct packed {
    logic              load;
    logic              clear;
    logic              wr_kernel;
    logic              wr_pixel;
    logic              tap_vld;
    logic [KIDX_W-1:0] tap_a;
    logic [KIDX_W-1:0] tap_b;
    logic              finish;
    status_e           fin_status;
    logic              fin_sum;
  } c2d_cmd_t;

  typedef struct packed {
    kind_e            kind;
    logic             store_oob;
    logic             geom_bad;
    logic             query_oob;
    logic [KSZ_W-1:0] ksize;
  } c2d_stat_t;

endpackage

// ===== rtl/conv2d_valid_or_same_padding.sv =====
// top level of the 2-D convolution engine (valid or same padding)
`timescale 1ns / 1ps

// An item is taken when start is high and busy is low. Every item gives one result beat,
// shown on out_o for exactly one cycle with done_o high; the receiver cannot stall it.
// Coefficient and pixel writes, and computes rejected for range or geometry, go from the check
// state straight back to idle. A compute walks the K*K kernel taps through a single
// multiply-accumulate unit, one tap per cycle (registered store read, registered product,
// accumulate). busy drops in the cycle the result beat is shown. Store contents are
// undefined until written.

`include "conv2d_valid_or_same_padding_assert.svh"

module conv2d_valid_or_same_padding (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  c2d_pkg::c2d_in_t               in_i,
  output c2d_pkg::c2d_out_t              out_o,
  output logic                           done_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [c2d_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [c2d_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  c2d_pkg::c2d_cmd_t  cmd;
  c2d_pkg::c2d_stat_t stat;

  assign cfg_ready_o = 1'b1;

  c2d_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  c2d_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_o       (out_o),
    .done_o      (done_o)
  );

  `C2D_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `C2D_ASSERT_NEXT(a_single_beat, done_o, !done_o)
  `C2D_ASSERT_NOW(a_err_zero, done_o && (out_o.status != c2d_pkg::ST_OK), out_o.conv_sum == '0)
  `C2D_ASSERT_NEXT(a_finish_beat, cmd.finish, done_o && !busy)

endmodule

// ===== rtl/c2d_ctrl.sv =====
// sequencer: item decode, tap walk and result timing
`timescale 1ns / 1ps

module c2d_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  c2d_pkg::c2d_stat_t stat_i,
  output c2d_pkg::c2d_cmd_t  cmd_o
);

  localparam int DRAIN_LEN = 2;
  localparam int DRN_W     = $clog2(DRAIN_LEN);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RUN,
    S_DRAIN,
    S_FINISH
  } state_e;

  state_e                     state_q, state_d;
  logic [c2d_pkg::KIDX_W-1:0] a_q, a_d, b_q, b_d;
  logic [DRN_W-1:0]           drn_q, drn_d;
  logic                       a_last, b_last;

  assign a_last = (c2d_pkg::KSZ_W'(a_q) == stat_i.ksize - 1'b1);
  assign b_last = (c2d_pkg::KSZ_W'(b_q) == stat_i.ksize - 1'b1);

  always_comb begin
    cmd_o            = '0;
    cmd_o.fin_status = c2d_pkg::ST_OK;
    cmd_o.tap_a      = a_q;
    cmd_o.tap_b      = b_q;
    busy             = (state_q != S_IDLE);
    cmd_o.load       = start && !busy;
    state_d          = state_q;
    a_d              = a_q;
    b_d              = b_q;
    drn_d            = drn_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.load) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        unique case (stat_i.kind)
          c2d_pkg::KIND_KWR, c2d_pkg::KIND_PWR: begin
            cmd_o.wr_kernel  = (stat_i.kind == c2d_pkg::KIND_KWR) && !stat_i.store_oob;
            cmd_o.wr_pixel   = (stat_i.kind == c2d_pkg::KIND_PWR) && !stat_i.store_oob;
            cmd_o.finish     = 1'b1;
            cmd_o.fin_status = stat_i.store_oob ? c2d_pkg::ST_RANGE : c2d_pkg::ST_OK;
            state_d          = S_IDLE;
          end
          c2d_pkg::KIND_CONV: begin
            if (stat_i.geom_bad) begin
              cmd_o.finish     = 1'b1;
              cmd_o.fin_status = c2d_pkg::ST_GEOM;
              state_d          = S_IDLE;
            end else if (stat_i.query_oob) begin
              cmd_o.finish     = 1'b1;
              cmd_o.fin_status = c2d_pkg::ST_RANGE;
              state_d          = S_IDLE;
            end else begin
              cmd_o.clear = 1'b1;
              a_d         = '0;
              b_d         = '0;
              state_d     = S_RUN;
            end
          end
          default: begin
            cmd_o.finish     = 1'b1;
            cmd_o.fin_status = c2d_pkg::ST_RANGE;
            state_d          = S_IDLE;
          end
        endcase
      end
      S_RUN: begin
        cmd_o.tap_vld = 1'b1;
        if (b_last) begin
          b_d = '0;
          if (a_last) begin
            drn_d   = '0;
            state_d = S_DRAIN;
          end else begin
            a_d = a_q + 1'b1;
          end
        end else begin
          b_d = b_q + 1'b1;
        end
      end
      S_DRAIN: begin
        drn_d = drn_q + 1'b1;
        if (drn_q == DRN_W'(DRAIN_LEN - 1)) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd_o.finish  = 1'b1;
        cmd_o.fin_sum = 1'b1;
        state_d       = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      a_q     <= '0;
      b_q     <= '0;
      drn_q   <= '0;
    end else begin
      state_q <= state_d;
      a_q     <= a_d;
      b_q     <= b_d;
      drn_q   <= drn_d;
    end
  end

endmodule

// ===== rtl/c2d_dp.sv =====
// datapath: config registers, stores, tap addressing, multiply-accumulate, result register
`timescale 1ns / 1ps

module c2d_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  c2d_pkg::c2d_in_t                    in_i,
  input  logic                                cfg_valid_i,
  input  logic [c2d_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [c2d_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  c2d_pkg::c2d_cmd_t                   cmd_i,
  output c2d_pkg::c2d_stat_t                  stat_o,
  output c2d_pkg::c2d_out_t                   out_o,
  output logic                                done_o
);

  localparam int KDEPTH = c2d_pkg::MAX_KERNEL * c2d_pkg::MAX_KERNEL;
  localparam int PDEPTH = c2d_pkg::MAX_DIM * c2d_pkg::MAX_DIM;

  logic [c2d_pkg::KSZ_W-1:0] ksize_q;
  logic [c2d_pkg::DIM_W-1:0] idim_q;
  logic                      pad_q;

  c2d_pkg::c2d_in_t item_q;

  logic [c2d_pkg::DATA_WIDTH-1:0] kmem [KDEPTH];
  logic [c2d_pkg::DATA_WIDTH-1:0] pmem [PDEPTH];

  logic signed [c2d_pkg::DATA_WIDTH-1:0] kdat_q, pdat_q;
  logic signed [c2d_pkg::PROD_W-1:0]     prod_q;
  logic signed [c2d_pkg::SUM_W-1:0]      acc_q;
  logic                                  v1_q, v2_q;

  c2d_pkg::c2d_out_t out_q;
  logic              done_q;

  logic [c2d_pkg::DIM_W-1:0]   osize;
  logic [c2d_pkg::KSZ_W-2:0]   pad_amt;
  logic [c2d_pkg::TAP_W-1:0]   pr, pc;
  logic                        tap_in;
  logic [2*c2d_pkg::KIDX_W-1:0] kwaddr, kraddr;
  logic [2*c2d_pkg::PIDX_W-1:0] pwaddr, praddr;

  // config port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ksize_q <= c2d_pkg::KSZ_RESET;
      idim_q  <= c2d_pkg::DIM_RESET;
      pad_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        c2d_pkg::CFG_KSIZE: ksize_q <= cfg_data_i[c2d_pkg::KSZ_W-1:0];
        c2d_pkg::CFG_IDIM:  idim_q  <= cfg_data_i[c2d_pkg::DIM_W-1:0];
        c2d_pkg::CFG_PAD:   pad_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_i;
    end
  end

  // item checks
  assign osize   = pad_q ? idim_q : idim_q - c2d_pkg::DIM_W'(ksize_q) + 1'b1;
  assign pad_amt = pad_q ? ksize_q[c2d_pkg::KSZ_W-1:1] : '0;

  always_comb begin
    stat_o       = '0;
    stat_o.kind  = c2d_pkg::kind_e'(item_q.kind);
    stat_o.ksize = ksize_q;
    if (item_q.kind == c2d_pkg::KIND_KWR) begin
      stat_o.store_oob = (item_q.row >= c2d_pkg::MAX_KERNEL) ||
                         (item_q.col >= c2d_pkg::MAX_KERNEL);
    end else begin
      stat_o.store_oob = (item_q.row >= c2d_pkg::MAX_DIM) ||
                         (item_q.col >= c2d_pkg::MAX_DIM);
    end
    stat_o.geom_bad  = (ksize_q == '0) ||
                       (ksize_q > c2d_pkg::KSZ_W'(c2d_pkg::MAX_KERNEL)) ||
                       (idim_q == '0) ||
                       (idim_q > c2d_pkg::DIM_W'(c2d_pkg::MAX_DIM)) ||
                       (c2d_pkg::DIM_W'(ksize_q) > idim_q);
    stat_o.query_oob = (c2d_pkg::DIM_W'(item_q.row) >= osize) ||
                       (c2d_pkg::DIM_W'(item_q.col) >= osize);
  end

  // tap addressing
  assign pr = c2d_pkg::TAP_W'(item_q.row) + c2d_pkg::TAP_W'(cmd_i.tap_a) -
              c2d_pkg::TAP_W'(pad_amt);
  assign pc = c2d_pkg::TAP_W'(item_q.col) + c2d_pkg::TAP_W'(cmd_i.tap_b) -
              c2d_pkg::TAP_W'(pad_amt);
  assign tap_in = !pr[c2d_pkg::TAP_W-1] && (pr < c2d_pkg::TAP_W'(idim_q)) &&
                  !pc[c2d_pkg::TAP_W-1] && (pc < c2d_pkg::TAP_W'(idim_q));

  assign kwaddr = {item_q.row[c2d_pkg::KIDX_W-1:0], item_q.col[c2d_pkg::KIDX_W-1:0]};
  assign pwaddr = {item_q.row[c2d_pkg::PIDX_W-1:0], item_q.col[c2d_pkg::PIDX_W-1:0]};
  assign kraddr = {cmd_i.tap_a, cmd_i.tap_b};
  assign praddr = {pr[c2d_pkg::PIDX_W-1:0], pc[c2d_pkg::PIDX_W-1:0]};

  // stores
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_kernel) begin
      kmem[kwaddr] <= item_q.data_value;
    end
    kdat_q <= kmem[kraddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_pixel) begin
      pmem[pwaddr] <= item_q.data_value;
    end
    pdat_q <= pmem[praddr];
  end

  // multiply-accumulate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.tap_vld && tap_in;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= kdat_q * pdat_q;
    if (cmd_i.clear) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + c2d_pkg::SUM_W'(prod_q);
    end
  end

  // result beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q.conv_sum <= cmd_i.fin_sum ? acc_q : '0;
      out_q.status   <= cmd_i.fin_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
    end
  end

  assign out_o  = out_q;
  assign done_o = done_q;

endmodule
